// ===== rtl/core/cmwm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cmwm_pkg;

    localparam int MAX_COLUMNS = 512;
    localparam int ADDR_W      = $clog2(MAX_COLUMNS);
    localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);

    localparam int OFF_W  = 12;
    localparam int PREV_W = 5;

    localparam int HEIGHT_W = 11;
    localparam int WIDTH_W  = 10;
    localparam int STEP_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 11'd200;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 10'd320;
    localparam logic [STEP_W-1:0]   STEP_RST   = 7'd8;

    localparam logic [10:0]         SLOW_LIMIT = 11'd16;
    localparam logic signed [6:0]   INIT_FLOOR = -7'sd16;
    localparam logic signed [4:0]   INIT_RAISE = -5'sd15;

    typedef enum logic [1:0] {
        REQ_INIT  = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_QUERY = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT    = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_FAST_STEP = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] req_type;
        logic [8:0] column;
        logic [9:0] row;
        logic [7:0] rand_byte;
        logic [3:0] tick_count;
    } t_in_beat;

    typedef struct packed {
        logic       done_res;
        logic       use_end_screen;
        logic [9:0] source_row;
    } t_out_beat;

    // r mod 3: base-4 digit sum, then fold
    function automatic logic [1:0] mod3(input logic [7:0] r);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(r[1:0]) + 4'(r[3:2]) + 4'(r[5:4]) + 4'(r[7:6]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cmwm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmwm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/column_melt_wipe_mapper_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Column melt wipe mapper. Per-column signed melt offsets live in one
// 512 x 12 synchronous memory; they are undefined until an init beat writes
// them, so every column that is ticked or queried must be initialized first.
// Init, query and unknown beats are taken one per cycle unless the output
// stalls, and return their result beat through stage one and the output
// register. A tick beat walks the memory once per tick with one read and
// one write-back per column over n = min(screen_width, 512) columns;
// no new beat is taken during the walk.
// A tick beat with tick_count 0 behaves like an init beat in timing.
// Configuration writes are taken in any cycle.
module column_melt_wipe_mapper_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [cmwm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [cmwm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire cmwm_pkg::t_in_beat          i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output cmwm_pkg::t_out_beat              o_out_data
);

    import cmwm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_SWEEP = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [HEIGHT_W-1:0] r_height;
    logic [WIDTH_W-1:0]  r_width;
    logic [STEP_W-1:0]   r_step;
    logic signed [PREV_W-1:0] r_prev, n_prev;

    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic [3:0]        r_ticks, n_ticks;
    logic              r_active, n_active;

    logic        r_s1_vld, n_s1_vld;
    logic        r_s1_query, n_s1_query;
    logic        r_s1_col_ok, n_s1_col_ok;
    logic        r_s1_done, n_s1_done;
    logic [9:0]  r_s1_row, n_s1_row;

    logic        r_out_vld, n_out_vld;
    t_out_beat   r_out, n_out;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [OFF_W-1:0]  ram_wdata, ram_rdata;

    logic             s1_adv, in_acc, col_ok, issue;
    logic [CNT_W-1:0] ncols;

    // init value
    logic signed [6:0]        init_sum;
    logic signed [PREV_W-1:0] init_val;

    // tick update of the pending column
    logic signed [OFF_W-1:0] t_off;
    logic [OFF_W-1:0]        t_dy;
    logic [OFF_W:0]          t_sum;
    logic [OFF_W-1:0]        t_new;
    logic                    t_act;

    // query
    logic signed [OFF_W-1:0] q_off;
    logic [HEIGHT_W-1:0]     q_offp;

    cmwm_ram #(
        .WIDTH(OFF_W),
        .DEPTH(MAX_COLUMNS)
    ) u_offsets (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && (!r_s1_vld || s1_adv);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign s1_adv = r_s1_vld && (!r_out_vld || i_out_ready);
    assign in_acc = i_in_valid && o_in_ready;
    assign col_ok = 32'(i_in_data.column) < MAX_COLUMNS;
    assign ncols  = (32'(r_width) < MAX_COLUMNS) ? CNT_W'(r_width) : CNT_W'(MAX_COLUMNS);
    assign issue  = (r_state == S_SWEEP) && (r_idx < ncols);

    always_comb begin
        init_sum = 7'(r_prev) + 7'(mod3(i_in_data.rand_byte)) - 7'sd1;
        if (i_in_data.column == '0) begin
            init_val = 5'sd0 - 5'(i_in_data.rand_byte[3:0]);
        end else if (init_sum > 7'sd0) begin
            init_val = '0;
        end else if (init_sum == INIT_FLOOR) begin
            init_val = INIT_RAISE;
        end else begin
            init_val = init_sum[PREV_W-1:0];
        end
    end

    always_comb begin
        t_off = ram_rdata;
        t_dy  = '0;
        t_sum = '0;
        t_new = ram_rdata;
        t_act = 1'b0;
        if (t_off[OFF_W-1]) begin
            t_new = ram_rdata + 12'd1;
            t_act = 1'b1;
        end else if (t_off[10:0] < r_height) begin
            t_dy  = (t_off[10:0] < SLOW_LIMIT) ? ({1'b0, t_off[10:0]} + 12'd1)
                                               : 12'(r_step);
            t_sum = {2'b00, t_off[10:0]} + {1'b0, t_dy};
            t_new = (t_sum >= 13'(r_height)) ? 12'(r_height) : t_sum[OFF_W-1:0];
            t_act = 1'b1;
        end
    end

    always_comb begin
        q_off  = r_s1_col_ok ? ram_rdata : '0;
        q_offp = q_off[OFF_W-1] ? '0 : q_off[10:0];
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wr_addr;
        ram_wdata = t_new;
        ram_re    = 1'b0;
        ram_raddr = r_idx[ADDR_W-1:0];

        n_state   = r_state;
        n_prev    = r_prev;
        n_idx     = r_idx;
        n_pend    = 1'b0;
        n_wr_addr = r_wr_addr;
        n_ticks   = r_ticks;
        n_active  = r_active;

        n_s1_vld    = s1_adv ? 1'b0 : r_s1_vld;
        n_s1_query  = r_s1_query;
        n_s1_col_ok = r_s1_col_ok;
        n_s1_done   = r_s1_done;
        n_s1_row    = r_s1_row;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_s1_vld    = 1'b1;
                    n_s1_query  = 1'b0;
                    n_s1_done   = 1'b0;
                    n_s1_col_ok = col_ok;
                    n_s1_row    = i_in_data.row;
                    case (i_in_data.req_type)
                        REQ_INIT: begin
                            if (col_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = ADDR_W'(i_in_data.column);
                                ram_wdata = 12'(init_val);
                                n_prev    = init_val;
                            end
                        end
                        REQ_TICK: begin
                            if (i_in_data.tick_count == '0) begin
                                n_s1_done = 1'b1;
                            end else begin
                                n_s1_vld = 1'b0;
                                n_state  = S_SWEEP;
                                n_idx    = '0;
                                n_ticks  = i_in_data.tick_count;
                                n_active = 1'b0;
                            end
                        end
                        REQ_QUERY: begin
                            n_s1_query = 1'b1;
                            ram_re     = 1'b1;
                            ram_raddr  = ADDR_W'(i_in_data.column);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                if (issue) begin
                    ram_re    = 1'b1;
                    n_idx     = r_idx + 1'b1;
                    n_pend    = 1'b1;
                    n_wr_addr = r_idx[ADDR_W-1:0];
                end
                if (r_pend) begin
                    ram_we   = 1'b1;
                    n_active = r_active || t_act;
                end
                if (!issue && !r_pend) begin
                    if (r_ticks == 4'd1) begin
                        n_state    = S_IDLE;
                        n_s1_vld   = 1'b1;
                        n_s1_query = 1'b0;
                        n_s1_done  = !r_active;
                    end else begin
                        n_ticks = r_ticks - 4'd1;
                        n_idx   = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = s1_adv ? 1'b1 : (i_out_ready ? 1'b0 : r_out_vld);
        n_out     = r_out;
        if (s1_adv) begin
            n_out = '0;
            if (r_s1_query) begin
                if ({1'b0, r_s1_row} < q_offp) begin
                    n_out.use_end_screen = 1'b1;
                    n_out.source_row     = r_s1_row;
                end else begin
                    n_out.source_row = r_s1_row - q_offp[9:0];
                end
            end else begin
                n_out.done_res = r_s1_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_height  <= HEIGHT_RST;
            r_width   <= WIDTH_RST;
            r_step    <= STEP_RST;
            r_prev    <= '0;
            r_pend    <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_prev    <= n_prev;
            r_pend    <= n_pend;
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HEIGHT:    r_height <= i_cfg_data[HEIGHT_W-1:0];
                    CFG_WIDTH:     r_width  <= i_cfg_data[WIDTH_W-1:0];
                    CFG_FAST_STEP: r_step   <= i_cfg_data[STEP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_wr_addr   <= n_wr_addr;
        r_ticks     <= n_ticks;
        r_active    <= n_active;
        r_s1_query  <= n_s1_query;
        r_s1_col_ok <= n_s1_col_ok;
        r_s1_done   <= n_s1_done;
        r_s1_row    <= n_s1_row;
        r_out       <= n_out;
    end

    a_sweep_no_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SWEEP |-> !r_s1_vld)
        else $error("stage one busy during column walk");

    a_pend_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_state == S_SWEEP)
        else $error("write-back pending outside column walk");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("read and write of the same column in one cycle");

    a_sweep_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SWEEP |-> !o_in_ready)
        else $error("beat taken during column walk");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_adv |=> r_s1_vld)
        else $error("stage one lost a beat");

endmodule

`default_nettype wire
